// ----- src/bsdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdc_pkg
// Shared types and constants of the beeper sampler with its DC blocking filter.
// ----------------------------------------------------------------------------
package bsdc_pkg;

   // Frame buffer depth in slots
   localparam int FRAME_SLOTS = 1024;
   localparam int FILL_W      = $clog2(FRAME_SLOTS + 1);

   // Field widths
   localparam int TACT_W   = 32;
   localparam int POINT_W  = 48;
   localparam int FRAC_W   = 16;
   localparam int ALPHA_W  = 16;
   localparam int PERIOD_W = 16;
   localparam int SAMPLE_W = 18;
   localparam int SLOT_W   = 10;
   localparam int COUNT_W  = 32;

   // Filter arithmetic
   localparam int PF_W   = 20;                      // stored filter output, Q3.16
   localparam int PROD_W = ALPHA_W + 1 + PF_W;      // signed alpha * y'
   localparam int RND_W  = PROD_W + 1;
   localparam int FB_W   = RND_W - FRAC_W;
   localparam int Y_W    = FB_W + 1;

   // Oscillator divider
   localparam int DIV_STEPS = TACT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SAMPLE_STEP = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DC_ALPHA    = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_OSC_PERIOD  = 5'd16;
   localparam logic [PERIOD_W-1:0]   OSC_PERIOD_RESET = 16'd512;

   typedef enum logic [1:0] {
      CMD_CLOCK_STEP = 2'd0,
      CMD_INSTR_END  = 2'd1,
      CMD_NEW_FRAME  = 2'd2,
      CMD_RESTART    = 2'd3
   } cmd_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
      logic div_run;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    take;
      logic    out_free;
      logic    div_last;
   } ctrl_status_type;

endpackage

// ----- src/bsdc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdc_ctrl
// Sequencer: accepts beats, runs the filter commit and the oscillator divider.
// ----------------------------------------------------------------------------
module bsdc_ctrl import bsdc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILTER,
      ST_DIVIDE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.commit  = 1'b0;
      cmd.div_run = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.cmd == CMD_CLOCK_STEP && status.take) begin
                  state_in = ST_FILTER;
               end else if (status.cmd == CMD_INSTR_END) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_FILTER: begin
            // hold until the output register can take the result
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/bsdc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdc_dp
// Datapath: sample schedule, DC blocker, frame slots and oscillator divider.
// ----------------------------------------------------------------------------
module bsdc_dp import bsdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output ctrl_status_type      status,
   input  logic [POINT_W-1:0]   sample_step,
   input  logic [ALPHA_W-1:0]   dc_alpha,
   input  logic [PERIOD_W-1:0]  oscillator_period,
   input  logic [1:0]           req_cmd,
   input  logic [TACT_W-1:0]    req_tact_count,
   input  logic                 req_speaker_run,
   input  logic                 req_speaker_silence,
   input  logic                 req_ear_bit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic [SLOT_W-1:0]    rsp_sample_slot,
   output logic                 rsp_dropped,
   output logic [COUNT_W-1:0]   rsp_overflow_total
);

   // Architectural state
   logic [POINT_W-1:0]   next_point_ff, next_point_in;
   logic                 prev_level_ff, prev_level_in;
   logic signed [PF_W-1:0] prev_filtered_ff, prev_filtered_in;
   logic [FILL_W-1:0]    frame_fill_ff, frame_fill_in;
   logic [COUNT_W-1:0]   drop_count_ff, drop_count_in;
   logic                 osc_level_ff, osc_level_in;

   // Item in flight
   logic                 level_ff, level_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Divider
   logic [TACT_W-1:0]    div_num_ff, div_num_in;
   logic [PERIOD_W-1:0]  div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PERIOD_W-1:0]  period_eff;
   logic [PERIOD_W:0]    div_shift;
   logic                 div_q;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_dropped_ff, rsp_dropped_in;
   logic [COUNT_W-1:0]   rsp_total_ff, rsp_total_in;

   // Combinational helpers
   logic [POINT_W-1:0]   now_point;
   logic [POINT_W-1:0]   ahead;
   logic                 level_now;
   logic signed [RND_W-1:0] rnd;
   logic signed [FB_W-1:0]  fb;
   logic signed [Y_W-1:0]   step_term;
   logic signed [Y_W-1:0]   y_raw;
   logic signed [PF_W-1:0]  y_sat;
   logic signed [SAMPLE_W-1:0] y_clamp;
   logic                 frame_full;

   assign now_point = {req_tact_count, {FRAC_W{1'b0}}};
   assign ahead     = next_point_ff - now_point;
   assign level_now = req_speaker_run ? (!req_speaker_silence && osc_level_ff) : req_ear_bit;

   assign period_eff = (oscillator_period == '0) ? PERIOD_W'(1) : oscillator_period;
   assign div_shift  = {div_rem_ff, div_num_ff[TACT_W-1]};
   assign div_q      = div_shift >= {1'b0, period_eff};

   assign status.cmd      = cmd_type'(req_cmd);
   assign status.take     = (sample_step != '0) && ((ahead == '0) || ahead[POINT_W-1]);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.div_last = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   // Filter: y = x - x' + round(alpha * y'), saturate to Q3.16, clamp to [-1, 1]
   always_comb begin
      rnd = {prod_ff[PROD_W-1], prod_ff} + RND_W'(32768);
      fb  = rnd[RND_W-1:FRAC_W];
      step_term = '0;
      if (level_ff && !prev_level_ff) begin
         step_term = Y_W'(65536);
      end else if (!level_ff && prev_level_ff) begin
         step_term = -Y_W'(65536);
      end
      y_raw = {fb[FB_W-1], fb} + step_term;
      if (y_raw > Y_W'(524287)) begin
         y_sat = PF_W'(524287);
      end else if (y_raw < -Y_W'(524288)) begin
         y_sat = -PF_W'(524288);
      end else begin
         y_sat = y_raw[PF_W-1:0];
      end
      if (y_sat > PF_W'(65536)) begin
         y_clamp = SAMPLE_W'(65536);
      end else if (y_sat < -PF_W'(65536)) begin
         y_clamp = -SAMPLE_W'(65536);
      end else begin
         y_clamp = y_sat[SAMPLE_W-1:0];
      end
   end

   assign frame_full = frame_fill_ff >= FILL_W'(FRAME_SLOTS);

   always_comb begin
      next_point_in    = next_point_ff;
      prev_level_in    = prev_level_ff;
      prev_filtered_in = prev_filtered_ff;
      frame_fill_in    = frame_fill_ff;
      drop_count_in    = drop_count_ff;
      osc_level_in     = osc_level_ff;
      level_in         = level_ff;
      prod_in          = prod_ff;
      div_num_in       = div_num_ff;
      div_rem_in       = div_rem_ff;
      div_cnt_in       = div_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_sample_in    = rsp_sample_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_dropped_in   = rsp_dropped_ff;
      rsp_total_in     = rsp_total_ff;

      if (cmd.accept) begin
         case (status.cmd)
            CMD_CLOCK_STEP: begin
               level_in = level_now;
               prod_in  = PROD_W'($signed({1'b0, dc_alpha}) * prev_filtered_ff);
            end
            CMD_INSTR_END: begin
               div_num_in = req_tact_count;
               div_rem_in = '0;
               div_cnt_in = '0;
            end
            CMD_NEW_FRAME: frame_fill_in = '0;
            CMD_RESTART:   next_point_in = now_point + sample_step;
            default: ;
         endcase
      end

      if (cmd.div_run) begin
         // one quotient bit per cycle; only the last one is kept
         div_num_in = {div_num_ff[TACT_W-2:0], 1'b0};
         div_rem_in = div_q ? PERIOD_W'(div_shift - {1'b0, period_eff})
                            : div_shift[PERIOD_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (status.div_last) begin
            osc_level_in = div_q;
         end
      end

      if (cmd.commit) begin
         prev_level_in    = level_ff;
         prev_filtered_in = y_sat;
         next_point_in    = next_point_ff + sample_step;
         rsp_valid_in     = 1'b1;
         rsp_sample_in    = y_clamp;
         if (frame_full) begin
            drop_count_in  = drop_count_ff + COUNT_W'(1);
            rsp_slot_in    = '0;
            rsp_dropped_in = 1'b1;
            rsp_total_in   = drop_count_ff + COUNT_W'(1);
         end else begin
            frame_fill_in  = frame_fill_ff + FILL_W'(1);
            rsp_slot_in    = frame_fill_ff[SLOT_W-1:0];
            rsp_dropped_in = 1'b0;
            rsp_total_in   = drop_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_point_ff    <= '0;
         prev_level_ff    <= 1'b0;
         prev_filtered_ff <= '0;
         frame_fill_ff    <= '0;
         drop_count_ff    <= '0;
         osc_level_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         next_point_ff    <= next_point_in;
         prev_level_ff    <= prev_level_in;
         prev_filtered_ff <= prev_filtered_in;
         frame_fill_ff    <= frame_fill_in;
         drop_count_ff    <= drop_count_in;
         osc_level_ff     <= osc_level_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff       <= level_in;
      prod_ff        <= prod_in;
      div_num_ff     <= div_num_in;
      div_rem_ff     <= div_rem_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_sample_slot    = rsp_slot_ff;
   assign rsp_dropped        = rsp_dropped_ff;
   assign rsp_overflow_total = rsp_total_ff;

endmodule

// ----- src/beeper_sampler_dc_blocker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beeper_sampler_dc_blocker_top
// Speaker sampler with a one-pole DC blocking filter and frame slot tracking.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   cmd, tact_count, run, silence, ear
//   rsp      out        rsp_valid/rsp_ready   sample, slot, dropped, total
//   csr      in         APB psel/penable      sample_step, dc_alpha, osc period
//
// A beat that takes no sample is done on acceptance; a sampling clock step
// multiplies first, then rounds, saturates and commits. Instruction end sets
// the oscillator level from a one-bit-per-cycle divider over the tact count.
// Reset is synchronous and clears all filter and schedule state.
// A result waits in the output register; a sampling beat stalls only if the
// previous result is still held when its commit comes up.
// ----------------------------------------------------------------------------
module beeper_sampler_dc_blocker_top import bsdc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [TACT_W-1:0]           req_tact_count,
   input  logic                        req_speaker_run,
   input  logic                        req_speaker_silence,
   input  logic                        req_ear_bit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample,
   output logic [SLOT_W-1:0]           rsp_sample_slot,
   output logic                        rsp_dropped,
   output logic [COUNT_W-1:0]          rsp_overflow_total,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   logic [POINT_W-1:0]  sample_step_ff;
   logic [ALPHA_W-1:0]  dc_alpha_ff;
   logic [PERIOD_W-1:0] osc_period_ff;
   logic                csr_write;

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_step_ff <= '0;
         dc_alpha_ff    <= '0;
         osc_period_ff  <= OSC_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr)
            ADDR_SAMPLE_STEP: sample_step_ff <= csr_pwdata[POINT_W-1:0];
            ADDR_DC_ALPHA:    dc_alpha_ff    <= csr_pwdata[ALPHA_W-1:0];
            ADDR_OSC_PERIOD:  osc_period_ff  <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_SAMPLE_STEP: csr_prdata = CSR_DATA_W'(sample_step_ff);
         ADDR_DC_ALPHA:    csr_prdata = CSR_DATA_W'(dc_alpha_ff);
         ADDR_OSC_PERIOD:  csr_prdata = CSR_DATA_W'(osc_period_ff);
         default:          csr_prdata = '0;
      endcase
   end

   bsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   bsdc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctrl_cmd),
      .status              (ctrl_status),
      .sample_step         (sample_step_ff),
      .dc_alpha            (dc_alpha_ff),
      .oscillator_period   (osc_period_ff),
      .req_cmd             (req_cmd),
      .req_tact_count      (req_tact_count),
      .req_speaker_run     (req_speaker_run),
      .req_speaker_silence (req_speaker_silence),
      .req_ear_bit         (req_ear_bit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .rsp_sample_slot     (rsp_sample_slot),
      .rsp_dropped         (rsp_dropped),
      .rsp_overflow_total  (rsp_overflow_total)
   );

endmodule

// ----- sim/beeper_sampler_dc_blocker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beeper_sampler_dc_blocker_top_tb
// Self-checking bench for the speaker sampler and its DC blocking filter.
//
// Request beats go in with bursts and gaps. The receiver stalls randomly, on
// a rotating pattern, and for one long hold. An in-bench model predicts every
// sample beat: the schedule with counter wrap, the oscillator level, the
// one-pole filter with clamping, and the frame slots with overflow counting.
// Registers are written over APB between phases, and each write is read back.
// ----------------------------------------------------------------------------
module beeper_sampler_dc_blocker_top_tb;
   import bsdc_pkg::*;

   localparam int LATENCY_GUARD = 40;   // longest beat (instruction end) plus margin

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct {
      cmd_type           cmd;
      logic [TACT_W-1:0] tacts;
      logic              run;
      logic              silence;
      logic              ear;
   } speaker_beat_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [SLOT_W-1:0]          slot;
      logic                       dropped;
      logic [COUNT_W-1:0]         total;
   } audio_sample_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_cmd = CMD_CLOCK_STEP;
   logic [TACT_W-1:0]           req_tact_count = '0;
   logic                        req_speaker_run = 1'b0;
   logic                        req_speaker_silence = 1'b0;
   logic                        req_ear_bit = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample;
   logic [SLOT_W-1:0]           rsp_sample_slot;
   logic                        rsp_dropped;
   logic [COUNT_W-1:0]          rsp_overflow_total;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;

   // Predictor copy of the registers and the sampler state
   logic [POINT_W-1:0]  step_cfg   = '0;
   logic [ALPHA_W-1:0]  alpha_cfg  = '0;
   logic [PERIOD_W-1:0] period_cfg = OSC_PERIOD_RESET;
   logic [POINT_W-1:0]  next_point_q = '0;
   logic                level_q = 1'b0;
   int                  filt_q = 0;
   int unsigned         fill_q = 0;
   logic [COUNT_W-1:0]  drop_q = '0;
   logic                osc_q = 1'b0;

   audio_sample_type pending_samples[$];

   // Stimulus and receiver control
   logic [TACT_W-1:0] tact_now = '0;
   bit                sender_gaps = 1'b1;
   int                burst_left = 0;
   rx_mode_type       rx_mode = RX_RANDOM;
   logic [15:0]       rx_pattern = 16'h5F3B;
   int                rx_pos = 0;
   int                rx_hold_req = 0;
   int                rx_hold_left = 0;

   int mismatches = 0;
   int beats_sent = 0;
   int samples_checked = 0;
   int drops_checked = 0;

   beeper_sampler_dc_blocker_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_tact_count      (req_tact_count),
      .req_speaker_run     (req_speaker_run),
      .req_speaker_silence (req_speaker_silence),
      .req_ear_bit         (req_ear_bit),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .rsp_sample_slot     (rsp_sample_slot),
      .rsp_dropped         (rsp_dropped),
      .rsp_overflow_total  (rsp_overflow_total),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void check_field(input string what, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Advance the sampler model by one accepted beat; queue a sample if one is taken.
   function automatic void predict_sample(input speaker_beat_type b);
      logic [POINT_W-1:0]  now_pt;
      logic [POINT_W-1:0]  ahead;
      logic [PERIOD_W-1:0] period;
      logic [TACT_W-1:0]   quot;
      logic                lvl;
      longint              prod;
      longint              y;
      audio_sample_type    s;
      now_pt = {b.tacts, 16'h0000};
      case (b.cmd)
         CMD_INSTR_END: begin
            period = (period_cfg == 0) ? 16'd1 : period_cfg;
            quot   = b.tacts / period;
            osc_q  = quot[0];
         end
         CMD_NEW_FRAME: fill_q = 0;
         CMD_RESTART:   next_point_q = now_pt + step_cfg;
         CMD_CLOCK_STEP: begin
            ahead = next_point_q - now_pt;
            if (step_cfg != 0 && (ahead == 0 || ahead[POINT_W-1])) begin
               lvl  = b.run ? (b.silence ? 1'b0 : osc_q) : b.ear;
               prod = longint'(alpha_cfg) * longint'(filt_q);
               // round the feedback to nearest, halves up
               y = (longint'(lvl) - longint'(level_q)) * 65536 + ((prod + 32768) >>> 16);
               if (y > 524287) y = 524287;
               if (y < -524288) y = -524288;
               level_q = lvl;
               filt_q  = int'(y);
               if (y > 65536) y = 65536;
               if (y < -65536) y = -65536;
               s.sample = y[SAMPLE_W-1:0];
               if (fill_q < FRAME_SLOTS) begin
                  s.slot    = fill_q[SLOT_W-1:0];
                  s.dropped = 1'b0;
                  fill_q++;
               end else begin
                  s.slot    = '0;
                  s.dropped = 1'b1;
                  drop_q++;
               end
               s.total = drop_q;
               next_point_q = next_point_q + step_cfg;
               pending_samples.push_back(s);
            end
         end
      endcase
   endfunction

   function automatic speaker_beat_type beat_of(input cmd_type cmd,
                                                input logic [TACT_W-1:0] tacts,
                                                input logic run, input logic silence,
                                                input logic ear);
      speaker_beat_type b;
      b.cmd     = cmd;
      b.tacts   = tacts;
      b.run     = run;
      b.silence = silence;
      b.ear     = ear;
      return b;
   endfunction

   function automatic speaker_beat_type make_beat(input cmd_type cmd);
      return beat_of(cmd, tact_now, 1'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
   endfunction

   // Receiver: long hold on request, otherwise the current stall mode
   always @(posedge clock) begin
      if (rx_hold_req != 0) begin
         rx_hold_left = rx_hold_req;
         rx_hold_req  = 0;
      end
      if (rx_hold_left != 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_ready <= rx_pattern[rx_pos];
               rx_pos = (rx_pos + 1) % 16;
            end
         endcase
      end
   end

   always @(posedge clock) begin : check_samples
      audio_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: sample beat with nothing expected: expected none, got sample %0d",
                     $time, rsp_sample);
            mismatches++;
         end else begin
            want = pending_samples.pop_front();
            check_field("sample", want.sample, rsp_sample);
            check_field("sample_slot", want.slot, rsp_sample_slot);
            check_field("dropped", want.dropped, rsp_dropped);
            check_field("overflow_total", want.total, rsp_overflow_total);
            samples_checked++;
            if (want.dropped) drops_checked++;
         end
      end
   end

   task automatic send_beat(input speaker_beat_type b);
      if (sender_gaps && burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_cmd             <= b.cmd;
      req_tact_count      <= b.tacts;
      req_speaker_run     <= b.run;
      req_speaker_silence <= b.silence;
      req_ear_bit         <= b.ear;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_sample(b);
      beats_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_samples.size() != 0);
   endtask

   // Drop valid, drain all samples, then let a slow beat without a result finish.
   task automatic settle();
      go_quiet();
      wait_drained();
      repeat (LATENCY_GUARD) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic expect_register(input logic [CSR_ADDR_W-1:0] addr,
                                  input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, addr, '0, got);
      check_field("register readback", value, got);
   endtask

   task automatic set_register(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] ignored;
      csr_access(1'b1, addr, value, ignored);
      case (addr)
         ADDR_SAMPLE_STEP: step_cfg   = value[POINT_W-1:0];
         ADDR_DC_ALPHA:    alpha_cfg  = value[ALPHA_W-1:0];
         ADDR_OSC_PERIOD:  period_cfg = value[PERIOD_W-1:0];
         default: ;
      endcase
      expect_register(addr, value);
   endtask

   task automatic test_directed_cases();
      expect_register(ADDR_SAMPLE_STEP, '0);
      expect_register(ADDR_DC_ALPHA, '0);
      expect_register(ADDR_OSC_PERIOD, OSC_PERIOD_RESET);
      // zero step: a clock step takes nothing
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd50, 1'b0, 1'b0, 1'b1));
      settle();
      set_register(ADDR_SAMPLE_STEP, {32'd10, 16'h0000});
      set_register(ADDR_DC_ALPHA, 16'hFFFF);
      set_register(ADDR_OSC_PERIOD, 16'd0);
      send_beat(beat_of(CMD_RESTART, 32'd100, 1'b0, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd105, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd110, 1'b0, 1'b0, 1'b1));
      // zero period counts as one: odd tact count sets the oscillator
      send_beat(beat_of(CMD_INSTR_END, 32'd7, 1'b1, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd125, 1'b1, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd130, 1'b1, 1'b1, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd131, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd140, 1'b0, 1'b1, 1'b0));
      send_beat(beat_of(CMD_NEW_FRAME, 32'd145, 1'b0, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd150, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd100, 1'b0, 1'b0, 1'b0));
      // schedule across the counter wrap
      send_beat(beat_of(CMD_RESTART, 32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd2, 1'b0, 1'b0, 1'b0));
      // new step leaves the pending point alone; half-way feedback rounds up
      settle();
      set_register(ADDR_SAMPLE_STEP, {32'd3, 16'h0000});
      set_register(ADDR_DC_ALPHA, 16'h8000);
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd11, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd12, 1'b0, 1'b0, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd14, 1'b0, 1'b0, 1'b0));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd15, 1'b0, 1'b0, 1'b0));
      settle();
      set_register(ADDR_OSC_PERIOD, 16'hFFFF);
      send_beat(beat_of(CMD_INSTR_END, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
      send_beat(beat_of(CMD_CLOCK_STEP, 32'd18, 1'b1, 1'b0, 1'b0));
   endtask

   // Hold the receiver until the block stalls its input, then drain fully.
   task automatic test_backpressure();
      settle();
      set_register(ADDR_SAMPLE_STEP, {32'd1, 16'h0000});
      rx_mode     = RX_ALWAYS;
      sender_gaps = 1'b0;
      send_beat(make_beat(CMD_RESTART));
      rx_hold_req = 300;
      repeat (40) begin
         tact_now += 2;
         send_beat(make_beat(CMD_CLOCK_STEP));
      end
      go_quiet();
      wait_drained();
      repeat (10) begin
         tact_now += 1;
         send_beat(make_beat(CMD_CLOCK_STEP));
      end
      sender_gaps = 1'b1;
   endtask

   task automatic run_traffic_phase(input logic [POINT_W-1:0] step,
                                    input logic [ALPHA_W-1:0] alpha,
                                    input logic [PERIOD_W-1:0] period,
                                    input rx_mode_type mode,
                                    input bit gaps, input int beats);
      int unsigned span;
      int unsigned pick;
      settle();
      set_register(ADDR_SAMPLE_STEP, step);
      set_register(ADDR_DC_ALPHA, alpha);
      set_register(ADDR_OSC_PERIOD, period);
      rx_mode     = mode;
      rx_pattern  = 16'($urandom) | 16'h1111;
      sender_gaps = gaps;
      tact_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000);
      span = (step[47:16] == 0) ? 3 : (step[47:16] > 2000) ? 2000 : 2 * step[47:16] + 1;
      send_beat(make_beat(CMD_RESTART));
      repeat (beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            tact_now += $urandom_range(0, span);
            send_beat(make_beat(CMD_CLOCK_STEP));
         end else if (pick < 74) begin
            tact_now += $urandom_range(0, 64);
            send_beat(make_beat(CMD_INSTR_END));
         end else if (pick < 78) begin
            send_beat(make_beat(CMD_NEW_FRAME));
         end else if (pick < 82) begin
            send_beat(make_beat(CMD_RESTART));
         end else if (pick < 91) begin
            // jump the counter anywhere
            tact_now = $urandom;
            send_beat(make_beat(CMD_CLOCK_STEP));
         end else begin
            // stale count: step back
            tact_now -= $urandom_range(0, span);
            send_beat(make_beat(CMD_CLOCK_STEP));
         end
      end
   endtask

   task automatic test_random_traffic();
      logic [POINT_W-1:0] rnd_step;
      run_traffic_phase({32'd37, 16'h8000}, 16'hFF00, 16'd64, RX_RANDOM, 1'b1, 110);
      run_traffic_phase(48'hFFFF_FFFF_FFFF, 16'h0000, 16'd1, RX_PATTERN, 1'b1, 110);
      run_traffic_phase(48'd1, 16'hFFFF, 16'hFFFF, RX_ALWAYS, 1'b0, 110);
      rnd_step = (48'($urandom_range(1, 3000)) << 16) | 48'($urandom_range(0, 16'hFFFF));
      run_traffic_phase(rnd_step, 16'($urandom), 16'($urandom_range(1, 65535)),
                        RX_RANDOM, 1'b1, 110);
      run_traffic_phase(48'd0, 16'h8000, 16'd0, RX_PATTERN, 1'b1, 110);
      rnd_step = {16'($urandom), 32'($urandom)};
      run_traffic_phase(rnd_step, 16'($urandom), 16'($urandom_range(1, 65535)),
                        RX_RANDOM, 1'b1, 110);
      run_traffic_phase({32'd5, 16'h0000}, 16'($urandom), 16'd3, RX_RANDOM, 1'b0, 110);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_backpressure();
      test_random_traffic();
      settle();
      $display("covered %0d request beats: directed cases, backpressure, random traffic",
               beats_sent);
      $display("checked %0d samples, %0d of them dropped on a full frame",
               samples_checked, drops_checked);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d samples still expected", $time, pending_samples.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
src/bsdc_pkg.sv
src/bsdc_ctrl.sv
src/bsdc_dp.sv
src/beeper_sampler_dc_blocker_top.sv
sim/beeper_sampler_dc_blocker_top_tb.sv
